FILE: src/crtoi_pkg.sv
package crtoi_pkg;

  // symbol slots in the configuration registers
  localparam int SLOTS       = 16;
  localparam int SYM_W       = 8;
  localparam int DIGIT_W     = 4;
  localparam int CNT_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  // defaults for the top level parameters
  localparam int DEF_MAX_SYMBOLS = 16;
  localparam int DEF_VALUE_BITS  = 32;
  localparam int DEF_QUEUE_DEPTH = 4;

  // character codes
  localparam logic [SYM_W-1:0] CH_MINUS   = 8'h2d;
  localparam logic [SYM_W-1:0] CH_PLUS    = 8'h2b;
  localparam logic [SYM_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [SYM_W-1:0] CH_WS_LO   = 8'h09;
  localparam logic [SYM_W-1:0] CH_WS_HI   = 8'h0d;
  localparam logic [SYM_W-1:0] CH_NUL     = 8'h00;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYMBOLS_LOW  = 2'd0,
    REG_SYMBOLS_HIGH = 2'd1,
    REG_RADIX        = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  // parse phases
  typedef enum logic [1:0] {
    PH_SPACE = 2'd0,
    PH_SIGN  = 2'd1,
    PH_DIGIT = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  // classified character passed from front to back
  typedef struct packed {
    logic               last;
    logic               is_space;
    logic               is_minus;
    logic               is_plus;
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
  } item_t;

  // alphabet status derived from configuration
  typedef struct packed {
    logic [CNT_W-1:0] used;
    logic             ok;
  } alpha_t;

  function automatic logic is_ws(input logic [SYM_W-1:0] c);
    return ((c >= CH_WS_LO) && (c <= CH_WS_HI)) || (c == CH_SPACE);
  endfunction

endpackage

FILE: src/crtoi_fifo.sv
module crtoi_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = crtoi_pkg::DEF_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count beyond depth");
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !do_pop) |=> full) else $error("full queue lost an entry without a pop");
  a_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (empty && !do_push) |=> empty) else $error("empty queue gained an entry without a push");

endmodule

FILE: src/crtoi_cfg.sv
module crtoi_cfg #(
  parameter int MAX_SYMBOLS = crtoi_pkg::DEF_MAX_SYMBOLS
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          wr_en,
  input  logic [crtoi_pkg::CFG_IDX_W-1:0]               wr_idx,
  input  logic [crtoi_pkg::CFG_DATA_W-1:0]              wr_data,
  output logic [crtoi_pkg::SLOTS*crtoi_pkg::SYM_W-1:0]  symbols,
  output crtoi_pkg::alpha_t                             alpha
);

  localparam int SW = crtoi_pkg::SYM_W;
  localparam int CW = crtoi_pkg::CNT_W;

  logic [crtoi_pkg::CFG_DATA_W-1:0] sym_lo_r, sym_hi_r;
  logic [CW-1:0]                    radix_r;
  logic [CW-1:0]                    nominal;
  logic [CW-1:0]                    used;
  logic                             ok;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_lo_r <= '0;
      sym_hi_r <= '0;
      radix_r  <= '0;
    end else if (wr_en) begin
      unique case (crtoi_pkg::reg_idx_t'(wr_idx))
        crtoi_pkg::REG_SYMBOLS_LOW:  sym_lo_r <= wr_data;
        crtoi_pkg::REG_SYMBOLS_HIGH: sym_hi_r <= wr_data;
        crtoi_pkg::REG_RADIX:        radix_r  <= wr_data[CW-1:0];
        default: ;
      endcase
    end
  end

  assign symbols = {sym_hi_r, sym_lo_r};

  // radix clamped to the symbol limit
  assign nominal = (radix_r > CW'(MAX_SYMBOLS)) ? CW'(MAX_SYMBOLS) : radix_r;

  // symbols in use end before the first zero byte
  always_comb begin
    used = nominal;
    for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
      if ((CW'(i) < nominal) && (symbols[i*SW +: SW] == crtoi_pkg::CH_NUL)) begin
        used = CW'(i);
      end
    end
  end

  // alphabet checks: size, forbidden bytes, duplicates
  always_comb begin
    ok = (nominal >= CW'(2));
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (CW'(i) < nominal) begin
        if ((symbols[i*SW +: SW] == crtoi_pkg::CH_NUL) ||
            (symbols[i*SW +: SW] == crtoi_pkg::CH_MINUS) ||
            (symbols[i*SW +: SW] == crtoi_pkg::CH_PLUS) ||
            crtoi_pkg::is_ws(symbols[i*SW +: SW])) begin
          ok = 1'b0;
        end
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if ((CW'(j) < nominal) && (symbols[j*SW +: SW] == symbols[i*SW +: SW])) begin
            ok = 1'b0;
          end
        end
      end
    end
  end

  assign alpha.used = used;
  assign alpha.ok   = ok;

endmodule

FILE: src/crtoi_front.sv
module crtoi_front #(
  parameter int MAX_SYMBOLS = crtoi_pkg::DEF_MAX_SYMBOLS
) (
  input  logic [crtoi_pkg::SYM_W-1:0]                   ch,
  input  logic                                          last,
  input  logic [crtoi_pkg::SLOTS*crtoi_pkg::SYM_W-1:0]  symbols,
  input  logic [crtoi_pkg::CNT_W-1:0]                   used,
  output crtoi_pkg::item_t                              item
);

  localparam int SW = crtoi_pkg::SYM_W;
  localparam int CW = crtoi_pkg::CNT_W;

  logic                           hit;
  logic [crtoi_pkg::DIGIT_W-1:0]  idx;

  // lowest matching symbol among those in use
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
      if ((CW'(i) < used) && (symbols[i*SW +: SW] == ch)) begin
        hit = 1'b1;
        idx = crtoi_pkg::DIGIT_W'(i);
      end
    end
  end

  // classification
  assign item.last     = last;
  assign item.is_space = crtoi_pkg::is_ws(ch);
  assign item.is_minus = (ch == crtoi_pkg::CH_MINUS);
  assign item.is_plus  = (ch == crtoi_pkg::CH_PLUS);
  assign item.is_digit = hit;
  assign item.digit    = idx;

endmodule

FILE: src/crtoi_back.sv
module crtoi_back #(
  parameter int VALUE_BITS = crtoi_pkg::DEF_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  crtoi_pkg::item_t             item,
  input  logic                         item_valid,
  output logic                         item_pop,
  input  logic [crtoi_pkg::CNT_W-1:0]  used,
  input  logic                         res_full,
  output logic                         res_push,
  output logic [VALUE_BITS-1:0]        res_acc,
  output logic                         res_neg
);

  localparam int CW = crtoi_pkg::CNT_W;

  crtoi_pkg::phase_t        phase_r, phase_nxt;
  logic                     neg_r, neg_nxt;
  logic [VALUE_BITS-1:0]    acc_r, acc_nxt;
  logic [VALUE_BITS-1:0]    prod;
  crtoi_pkg::phase_t        ph;
  logic                     neg;
  logic [VALUE_BITS-1:0]    acc;

  // a last item waits until the result queue has room
  assign item_pop = item_valid && (!item.last || !res_full);
  assign res_push = item_pop && item.last;

  assign prod = acc_r * VALUE_BITS'(used);

  // phase walk for one character
  always_comb begin
    ph  = phase_r;
    neg = neg_r;
    acc = acc_r;
    if ((ph == crtoi_pkg::PH_SPACE) && !item.is_space) begin
      ph = crtoi_pkg::PH_SIGN;
    end
    if (ph == crtoi_pkg::PH_SIGN) begin
      if (item.is_minus) begin
        neg = !neg;
      end else if (!item.is_plus) begin
        ph = crtoi_pkg::PH_DIGIT;
      end
    end
    if (ph == crtoi_pkg::PH_DIGIT) begin
      if (item.is_digit) begin
        acc = prod + VALUE_BITS'(item.digit);
      end else begin
        ph = crtoi_pkg::PH_DONE;
      end
    end

    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    if (item_pop) begin
      if (item.last) begin
        phase_nxt = crtoi_pkg::PH_SPACE;
        neg_nxt   = 1'b0;
        acc_nxt   = '0;
      end else begin
        phase_nxt = ph;
        neg_nxt   = neg;
        acc_nxt   = acc;
      end
    end
  end

  assign res_acc = acc;
  assign res_neg = neg;

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= crtoi_pkg::PH_SPACE;
      neg_r   <= 1'b0;
      acc_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
    end
  end

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> (phase_r == crtoi_pkg::PH_SPACE) && !neg_r && (acc_r == '0))
    else $error("parse state not cleared after result");
  a_space_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == crtoi_pkg::PH_SPACE) |-> (!neg_r && (acc_r == '0)))
    else $error("sign or digits recorded during whitespace phase");
  a_hold_without_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !item_pop |=> $stable(acc_r) && $stable(neg_r) && $stable(phase_r))
    else $error("parse state moved without a transaction");

endmodule

FILE: src/custom_radix_text_to_integer_unit.sv
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+---------------------------------
// in_      | input     | push / full         | ch[7:0], last
// out_     | output    | pop / empty         | value[VALUE_BITS-1:0], alphabet_ok
// cfg_     | input     | valid / ready       | index[1:0], data[63:0]
//
// one character per cycle sustained unless a last character waits for room; a
// result reaches out_ after its last character (front queue, then result queue)
// the back part does one multiply-add per cycle if it pops, which sets the rate
// rst_n is synchronous active low; clears parse state, queues and registers
// a full result queue holds back last characters only; cfg_ready is always high
module custom_radix_text_to_integer_unit #(
  parameter int MAX_SYMBOLS = crtoi_pkg::DEF_MAX_SYMBOLS,
  parameter int VALUE_BITS  = crtoi_pkg::DEF_VALUE_BITS,
  parameter int QUEUE_DEPTH = crtoi_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [7:0]                        in_ch,
  input  logic                              in_last,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [VALUE_BITS-1:0]      out_value,
  output logic                              out_alphabet_ok,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crtoi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crtoi_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IW = $bits(crtoi_pkg::item_t);
  localparam int RW = VALUE_BITS + 2;

  logic [crtoi_pkg::SLOTS*crtoi_pkg::SYM_W-1:0] symbols;
  crtoi_pkg::alpha_t                             alpha;
  crtoi_pkg::item_t                              front_item, back_item;
  logic [IW-1:0]                                 back_bits;
  logic                                          mid_empty, mid_pop;
  logic                                          res_full, res_push;
  logic [VALUE_BITS-1:0]                         res_acc;
  logic                                          res_neg;
  logic [RW-1:0]                                 res_in, res_out;
  logic [VALUE_BITS-1:0]                         out_acc;
  logic                                          out_neg;

  assign cfg_ready = 1'b1;

  // configuration registers and alphabet status
  crtoi_cfg #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .symbols (symbols),
    .alpha   (alpha)
  );

  // character classification
  crtoi_front #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_front (
    .ch      (in_ch),
    .last    (in_last),
    .symbols (symbols),
    .used    (alpha.used),
    .item    (front_item)
  );

  // queue between front and back
  crtoi_fifo #(
    .W     (IW),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (front_item),
    .full    (in_full),
    .pop     (mid_pop),
    .rd_data (back_bits),
    .empty   (mid_empty)
  );

  assign back_item = crtoi_pkg::item_t'(back_bits);

  // parse state machine and accumulator
  crtoi_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (back_item),
    .item_valid (!mid_empty),
    .item_pop   (mid_pop),
    .used       (alpha.used),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_acc    (res_acc),
    .res_neg    (res_neg)
  );

  assign res_in = {res_acc, res_neg, alpha.ok};

  // result queue
  crtoi_fifo #(
    .W     (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_out),
    .empty   (out_empty)
  );

  // apply sign on the way out
  assign out_acc         = res_out[RW-1:2];
  assign out_neg         = res_out[1];
  assign out_alphabet_ok = res_out[0];
  assign out_value       = out_neg ? -out_acc : out_acc;

endmodule

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSYM          = crtoi_pkg::DEF_MAX_SYMBOLS;
  localparam int VBITS         = crtoi_pkg::DEF_VALUE_BITS;
  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 3000;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_ITEMS  = 480;
  localparam int RANDOM_PHASES = 8;

  // "0123456789ABCDEF" packed symbol 0 in the lowest byte
  localparam logic [63:0] HEX_LO = 64'h3736_3534_3332_3130;
  localparam logic [63:0] HEX_HI = 64'h4645_4443_4241_3938;

  typedef struct packed {
    logic [VBITS-1:0] value;
    logic             ok;
  } parse_result_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_push = 1'b0;
  logic                                in_full;
  logic [7:0]                          in_ch = '0;
  logic                                in_last = 1'b0;
  logic                                out_empty;
  logic                                out_pop = 1'b0;
  logic signed [VBITS-1:0]             out_value;
  logic                                out_alphabet_ok;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  crtoi_pkg::reg_idx_t                 cfg_index = crtoi_pkg::REG_SYMBOLS_LOW;
  logic [crtoi_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

  custom_radix_text_to_integer_unit #(
    .MAX_SYMBOLS(NSYM),
    .VALUE_BITS (VBITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_ch          (in_ch),
    .in_last        (in_last),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_value      (out_value),
    .out_alphabet_ok(out_alphabet_ok),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // parser mirror: configuration and parse state
  logic [63:0]        sym_lo = '0;
  logic [63:0]        sym_hi = '0;
  logic [4:0]         radix_reg = '0;
  crtoi_pkg::phase_t  ph = crtoi_pkg::PH_SPACE;
  logic               negative = 1'b0;
  logic [VBITS-1:0]   acc = '0;

  parse_result_t    pending_results[$];
  logic [7:0]       text_buf[$];
  int               err_count = 0;
  int               chars_sent = 0;
  int               hold_seq = 0;
  bit               pace_en = 1'b1;
  int               burst_left = 0;

  function automatic logic [7:0] symbol_of(int i);
    if (i < 8) return sym_lo[8*i +: 8];
    else return sym_hi[8*(i-8) +: 8];
  endfunction

  function automatic bit blank_char(logic [7:0] c);
    return (c inside {[crtoi_pkg::CH_WS_LO:crtoi_pkg::CH_WS_HI]}) ||
           (c == crtoi_pkg::CH_SPACE);
  endfunction

  // radix register clamped to the slot count
  function automatic int nominal_count();
    int n;
    n = radix_reg;
    if (n > NSYM) n = NSYM;
    return n;
  endfunction

  // symbols in use stop at the first zero byte
  function automatic int symbols_in_use();
    int n;
    n = nominal_count();
    for (int i = 0; i < n; i++)
      if (symbol_of(i) == crtoi_pkg::CH_NUL) return i;
    return n;
  endfunction

  function automatic bit alphabet_sound();
    int n;
    logic [7:0] s;
    n = nominal_count();
    if (n < 2) return 1'b0;
    for (int i = 0; i < n; i++) begin
      s = symbol_of(i);
      if (s == crtoi_pkg::CH_NUL || s == crtoi_pkg::CH_MINUS ||
          s == crtoi_pkg::CH_PLUS || blank_char(s)) return 1'b0;
      for (int j = i + 1; j < n; j++)
        if (symbol_of(j) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  // lowest matching index wins, -1 when not a digit
  function automatic int digit_value(logic [7:0] c);
    int n;
    n = symbols_in_use();
    for (int i = 0; i < n; i++)
      if (symbol_of(i) == c) return i;
    return -1;
  endfunction

  // advance the parse by one character, queue the value on the last one
  function automatic void parse_char(logic [7:0] c, logic lst);
    int d;
    parse_result_t r;
    if (ph == crtoi_pkg::PH_SPACE && !blank_char(c)) ph = crtoi_pkg::PH_SIGN;
    if (ph == crtoi_pkg::PH_SIGN) begin
      if (c == crtoi_pkg::CH_MINUS) negative = ~negative;
      else if (c != crtoi_pkg::CH_PLUS) ph = crtoi_pkg::PH_DIGIT;
    end
    if (ph == crtoi_pkg::PH_DIGIT) begin
      d = digit_value(c);
      if (d >= 0) acc = acc * VBITS'(symbols_in_use()) + VBITS'(d);
      else ph = crtoi_pkg::PH_DONE;
    end
    if (lst) begin
      r.value = negative ? -acc : acc;
      r.ok = alphabet_sound();
      pending_results.push_back(r);
      ph = crtoi_pkg::PH_SPACE;
      negative = 1'b0;
      acc = '0;
    end
  endfunction

  function automatic void flag_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic void put_str(string s);
    foreach (s[i]) text_buf.push_back(s[i]);
  endfunction

  // one input transaction, with random gaps between bursts
  task automatic send_char(input logic [7:0] c, input logic lst);
    int gap;
    if (pace_en && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 6);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_push <= 1'b1;
    in_ch   <= c;
    in_last <= lst;
    do @(posedge clk); while (in_full);
    parse_char(c, lst);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
    text_buf = {};
  endtask

  // wait for every result, then let in-flight characters retire
  task automatic drain_and_settle();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no re-raise
  task automatic write_reg(input crtoi_pkg::reg_idx_t idx, input logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      crtoi_pkg::REG_SYMBOLS_LOW:  sym_lo = d;
      crtoi_pkg::REG_SYMBOLS_HIGH: sym_hi = d;
      crtoi_pkg::REG_RADIX:        radix_reg = d[4:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [63:0] radix_word);
    drain_and_settle();
    write_reg(crtoi_pkg::REG_SYMBOLS_LOW, lo);
    write_reg(crtoi_pkg::REG_SYMBOLS_HIGH, hi);
    write_reg(crtoi_pkg::REG_UNUSED, {$urandom, $urandom});
    write_reg(crtoi_pkg::REG_RADIX, radix_word);
    cfg_valid <= 1'b0;
  endtask

  // distinct legal symbols, random radix, sometimes one bad symbol
  task automatic random_config();
    logic [7:0]  s[16];
    logic [63:0] lo, hi, rw;
    int          n, lim, j, kind, v;
    bit          clash;
    for (int i = 0; i < 16; i++) begin
      do begin
        s[i] = 8'($urandom_range(1, 255));
        clash = blank_char(s[i]) || s[i] == crtoi_pkg::CH_MINUS ||
                s[i] == crtoi_pkg::CH_PLUS;
        for (int k = 0; k < i; k++)
          if (s[k] == s[i]) clash = 1'b1;
      end while (clash);
    end
    case ($urandom_range(0, 9))
      0:       n = 16;
      1:       n = 2;
      2:       n = $urandom_range(17, 31);
      3:       n = $urandom_range(0, 1);
      default: n = $urandom_range(3, 15);
    endcase
    lim = (n > 16) ? 16 : ((n < 1) ? 1 : n);
    j = $urandom_range(0, lim - 1);
    kind = $urandom_range(0, 9);
    case (kind)
      7: s[j] = crtoi_pkg::CH_NUL;
      8: begin
        v = $urandom_range(0, 7);
        if (v == 0) s[j] = crtoi_pkg::CH_MINUS;
        else if (v == 1) s[j] = crtoi_pkg::CH_PLUS;
        else if (v == 2) s[j] = crtoi_pkg::CH_SPACE;
        else s[j] = 8'(v + 6);
      end
      9: s[j] = s[(j + $urandom_range(1, 15)) % 16];
      default: ;
    endcase
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = s[i];
      hi[8*i +: 8] = s[i+8];
    end
    rw = {$urandom, $urandom};
    rw[4:0] = n[4:0];
    load_config(lo, hi, rw);
  endtask

  // whitespace, signs, digits from the alphabet in use, then some tail
  function automatic void build_number();
    int u, v;
    repeat ($urandom_range(0, 3)) begin
      v = $urandom_range(8, 13);
      text_buf.push_back(v == 8 ? crtoi_pkg::CH_SPACE : 8'(v));
    end
    repeat ($urandom_range(0, 3))
      text_buf.push_back($urandom_range(0, 1) ? crtoi_pkg::CH_MINUS : crtoi_pkg::CH_PLUS);
    u = symbols_in_use();
    if (u > 0)
      repeat ($urandom_range(0, 12)) text_buf.push_back(symbol_of($urandom_range(0, u - 1)));
    repeat ($urandom_range(0, 2))
      text_buf.push_back($urandom_range(0, 3) == 0 ? crtoi_pkg::CH_MINUS :
                         8'($urandom_range(0, 255)));
    if (text_buf.size() == 0) text_buf.push_back(8'($urandom_range(0, 255)));
  endfunction

  // all-zero registers after reset: no symbols, invalid alphabet
  task automatic test_reset_defaults();
    put_str("7");
    send_text();
  endtask

  // leading blanks, sign toggling, and 32-bit wrap
  task automatic test_hex_signs();
    load_config(HEX_LO, HEX_HI, 64'd16);
    put_str(" -+-1A");
    send_text();
    put_str("-FFFFFFFFF");
    send_text();
  endtask

  // zero byte ends the digits, 0xff on its own gives zero
  task automatic test_extreme_chars();
    send_char("1", 1'b0);
    send_char(8'h00, 1'b0);
    send_char("2", 1'b1);
    send_char(8'hff, 1'b1);
  endtask

  // radix above the slot count with a duplicate, zero byte cut, base one
  task automatic test_odd_alphabets();
    load_config(HEX_LO, {8'h30, HEX_HI[55:0]}, 64'd31);
    put_str("10");
    send_text();
    load_config({HEX_LO[63:32], crtoi_pkg::CH_NUL, HEX_LO[23:0]}, HEX_HI, 64'd16);
    put_str("21");
    send_text();
    load_config(HEX_LO, HEX_HI, 64'd1);
    put_str("00");
    send_text();
  endtask

  // receiver holds off while the sender keeps pushing short numbers
  task automatic test_backpressure();
    load_config(HEX_LO, HEX_HI, 64'd16);
    pace_en = 1'b0;
    hold_seq++;
    repeat (30) begin
      text_buf.push_back(crtoi_pkg::CH_MINUS);
      text_buf.push_back(symbol_of($urandom_range(0, 15)));
      text_buf.push_back(symbol_of($urandom_range(0, 15)));
      send_text();
    end
    pace_en = 1'b1;
  endtask

  // random alphabets; mostly well-formed numbers, some raw noise
  task automatic test_random_text();
    int phase_start;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_config();
      pace_en = (p % 3 != 2);
      phase_start = chars_sent;
      while (chars_sent - phase_start < RANDOM_ITEMS / RANDOM_PHASES) begin
        if ($urandom_range(0, 4) != 0) build_number();
        else repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
        send_text();
      end
    end
    pace_en = 1'b1;
  endtask

  // receiver: a randomly chosen stall pattern, plus requested hold-offs
  initial begin
    int cyc, mode, stall_left, hold_left, hold_seen;
    cyc = 0;
    mode = 0;
    stall_left = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 256 == 0) mode = $urandom_range(0, 3);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        case (mode)
          0: out_pop <= 1'b1;
          1: out_pop <= 1'($urandom_range(0, 1));
          2: begin
            if (stall_left > 0) begin
              stall_left--;
              out_pop <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
              stall_left = $urandom_range(1, 12);
              out_pop <= 1'b0;
            end else begin
              out_pop <= 1'b1;
            end
          end
          default: out_pop <= (cyc % 3 == 0);
        endcase
      end
    end
  end

  // result check against the oldest expected transaction
  always @(posedge clk) begin
    parse_result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: value %0d alphabet_ok %0b",
                                out_value, out_alphabet_ok));
      end else begin
        want = pending_results.pop_front();
        if (out_value !== want.value)
          flag_mismatch($sformatf("value mismatch: expected %0d got %0d",
                                  $signed(want.value), out_value));
        if (out_alphabet_ok !== want.ok)
          flag_mismatch($sformatf("alphabet_ok mismatch: expected %0b got %0b",
                                  want.ok, out_alphabet_ok));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    int idle_cycles;
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_hex_signs();
    test_extreme_chars();
    test_odd_alphabets();
    test_backpressure();
    test_random_text();
    drain_and_settle();
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
